/* rtl/core/p2c_pkg.sv */
// Shared constants, types and functions of the planar-to-chunky palette core.
package p2c_pkg;

   // Group geometry and palette shape.
   localparam int P2C_PIXELS     = 16;
   localparam int P2C_COUNT_W    = $clog2(P2C_PIXELS);
   localparam int P2C_MAX_PLANES = 8;
   localparam int P2C_WORD_W     = 16;
   localparam int P2C_INDEX_W    = 8;
   localparam int P2C_DEPTH      = 256;
   localparam int P2C_ENTRY_W    = 32;

   // Configuration register widths and indexes.
   localparam int P2C_PLANES_W = 4;
   localparam int P2C_BYTES_W  = 3;
   localparam int P2C_CSR_W    = 4;
   localparam int P2C_CSR_IDX_W = 1;
   localparam logic [P2C_CSR_IDX_W-1:0] P2C_REG_SOURCE_PLANES = 1'b0;
   localparam logic [P2C_CSR_IDX_W-1:0] P2C_REG_PIXEL_BYTES   = 1'b1;

   // Reset values of the configuration registers.
   localparam logic [P2C_PLANES_W-1:0] P2C_PLANES_RESET = 4'd4;
   localparam logic [P2C_BYTES_W-1:0]  P2C_BYTES_RESET  = 3'd2;

   // Item modes.
   localparam logic P2C_MODE_LOAD    = 1'b0;
   localparam logic P2C_MODE_CONVERT = 1'b1;

   // Entry read in place of the all-ones index when planes are missing.
   localparam logic [P2C_INDEX_W-1:0] P2C_ALL_ONES_ENTRY = 8'd255;

   // Palette write request.
   typedef struct packed {
      logic                   en;
      logic [P2C_INDEX_W-1:0] addr;
      logic [P2C_ENTRY_W-1:0] data;
   } p2c_wr_type;

   // Palette read request for one pixel.
   typedef struct packed {
      logic                   en;
      logic [P2C_INDEX_W-1:0] addr;
      logic                   last;
   } p2c_rd_type;

   // Keeps the top bytes of a palette word, right-justified; out-of-range counts saturate.
   function automatic logic [P2C_ENTRY_W-1:0] p2c_justify(
      input logic [P2C_ENTRY_W-1:0] entry,
      input logic [P2C_BYTES_W-1:0] bytes
   );
      logic [P2C_ENTRY_W-1:0] result;
      case (bytes)
         3'd0, 3'd1, 3'd2: result = entry >> 16;
         3'd3:             result = entry >> 8;
         default:          result = entry;
      endcase
      return result;
   endfunction

endpackage

/* rtl/core/p2c_sequencer.sv */
// Pixel sequencer: holds a group's plane words; one palette read per cycle while room is set.
module p2c_sequencer
   import p2c_pkg::*;
#(
   parameter int MAX_PLANES = P2C_MAX_PLANES
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [P2C_WORD_W-1:0]   plane_words [MAX_PLANES],
   input  logic [P2C_PLANES_W-1:0] source_planes,
   input  logic                    room,
   output p2c_rd_type              rd,
   output logic                    ready
);

   logic [P2C_WORD_W-1:0]   planes_ff [MAX_PLANES];
   logic [P2C_COUNT_W-1:0]  count_ff, count_in;
   logic                    busy_ff, busy_in;
   logic                    issue, issue_last;
   logic [P2C_COUNT_W-1:0]  bit_sel;
   logic [P2C_PLANES_W-1:0] planes_eff;
   logic [P2C_INDEX_W-1:0]  raw_idx, mask, idx;
   logic                    substitute;

   // A read goes out whenever a group is in progress and the output side has room.
   assign issue      = busy_ff && room;
   assign issue_last = issue && (count_ff == P2C_COUNT_W'(P2C_PIXELS - 1));
   assign ready      = !busy_ff || issue_last;

   // The next group may start in the cycle the last read of the current one goes out.
   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
      end else if (issue) begin
         count_in = count_ff + 1'b1;
         if (issue_last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   // Plane words are captured when a group starts.
   always_ff @(posedge clock) begin
      if (start) begin
         planes_ff <= plane_words;
      end
   end

   // Plane count clamped to one through the plane maximum.
   always_comb begin
      if (source_planes == '0) begin
         planes_eff = P2C_PLANES_W'(1);
      end else if (source_planes > P2C_PLANES_W'(MAX_PLANES)) begin
         planes_eff = P2C_PLANES_W'(MAX_PLANES);
      end else begin
         planes_eff = source_planes;
      end
   end

   // The first pixel of a group comes from the most significant bit of each word.
   assign bit_sel = P2C_COUNT_W'(P2C_PIXELS - 1) - count_ff;

   // Index bit k comes from plane k, for the planes in use.
   always_comb begin
      raw_idx = '0;
      mask    = '0;
      for (int k = 0; k < MAX_PLANES; k++) begin
         raw_idx[k] = planes_ff[k][bit_sel];
         mask[k]    = (P2C_PLANES_W'(k) < planes_eff);
      end
      idx        = raw_idx & mask;
      substitute = (planes_eff < P2C_PLANES_W'(MAX_PLANES)) && (idx == mask);
   end

   assign rd.en   = issue;
   assign rd.addr = substitute ? P2C_ALL_ONES_ENTRY : idx;
   assign rd.last = issue_last;

   // The pixel counter only moves inside a group.
   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (count_ff == '0))
      else $error("pixel counter nonzero while idle");

   // After the last read the sequencer is idle unless a new group started.
   a_end_group: assert property (@(posedge clock) disable iff (reset)
      (issue_last && !start) |=> !busy_ff)
      else $error("sequencer still busy after the last pixel");

endmodule

/* rtl/core/p2c_palette.sv */
// Palette memory with per-entry valid bits and a registered read port.
module p2c_palette
   import p2c_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  p2c_wr_type             wr,
   input  p2c_rd_type             rd,
   input  logic [P2C_BYTES_W-1:0] pixel_bytes,
   output logic                   out_valid,
   output logic [P2C_ENTRY_W-1:0] out_value,
   output logic                   out_last
);

   logic [P2C_ENTRY_W-1:0] mem [P2C_DEPTH];
   logic [P2C_DEPTH-1:0]   valid_ff;
   logic [P2C_ENTRY_W-1:0] rd_data_ff;
   logic                   rd_hit_ff;
   logic                   rd_last_ff;
   logic                   rd_valid_ff;

   // Memory array; a read in the same cycle as a write returns the old word.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
         rd_hit_ff  <= valid_ff[rd.addr];
         rd_last_ff <= rd.last;
      end
   end

   // Valid bits stand in for clearing the array; an entry never written reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd.en;
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
      end
   end

   assign out_valid = rd_valid_ff;
   assign out_value = p2c_justify(rd_hit_ff ? rd_data_ff : '0, pixel_bytes);
   assign out_last  = rd_last_ff;

endmodule

/* rtl/core/p2c_out_queue.sv */
// Two-beat output queue for pixels, with credit for the read in flight.
module p2c_out_queue
   import p2c_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [P2C_ENTRY_W-1:0] push_value,
   input  logic                   push_last,
   input  logic                   in_flight,
   output logic                   room,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [P2C_ENTRY_W-1:0] rsp_pixel_value,
   output logic                   rsp_last_pixel
);

   logic [P2C_ENTRY_W-1:0] value_ff [2];
   logic [1:0]             last_ff;
   logic [1:0]             count_ff, count_in;
   logic                   wr_ptr_ff, rd_ptr_ff;
   logic                   pop;
   logic [2:0]             occupancy;

   assign rsp_valid       = (count_ff != 2'd0);
   assign pop             = rsp_valid && !rsp_stall;
   assign rsp_pixel_value = value_ff[rd_ptr_ff];
   assign rsp_last_pixel  = last_ff[rd_ptr_ff];

   // Beats held plus the read on its way; a new read may go if one slot stays free.
   assign occupancy = 3'(count_ff) + 3'(in_flight) - 3'(pop);
   assign room      = (occupancy < 3'd2);

   assign count_in = count_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   // Payload slots.
   always_ff @(posedge clock) begin
      if (push) begin
         value_ff[wr_ptr_ff] <= push_value;
         last_ff[wr_ptr_ff]  <= push_last;
      end
   end

   // The credit scheme keeps the queue within its two slots.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < 2'd2 || pop))
      else $error("pixel pushed into a full queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("queue count out of range");

endmodule

/* rtl/core/planar_to_chunky_palette_core.sv */
// A convert sets the busy flag; its pixels pass the palette read register and output queue.
// Throughput: one pixel per cycle from one palette read port while the output has room.
// A load gives no beat; it is accepted when no group is in progress or its last read goes out.
// Reset (synchronous) clears the palette valid bits, so every entry reads as zero until
// written, and sets the plane count to 4 and the byte count to 2; no clearing pass is needed.
module planar_to_chunky_palette_core
   import p2c_pkg::*;
#(
   parameter int MAX_PLANES = P2C_MAX_PLANES
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_mode,
   input  logic [P2C_INDEX_W-1:0]   req_palette_index,
   input  logic [P2C_ENTRY_W-1:0]   req_palette_value,
   input  logic [P2C_WORD_W-1:0]    req_plane_word_0,
   input  logic [P2C_WORD_W-1:0]    req_plane_word_1,
   input  logic [P2C_WORD_W-1:0]    req_plane_word_2,
   input  logic [P2C_WORD_W-1:0]    req_plane_word_3,
   input  logic [P2C_WORD_W-1:0]    req_plane_word_4,
   input  logic [P2C_WORD_W-1:0]    req_plane_word_5,
   input  logic [P2C_WORD_W-1:0]    req_plane_word_6,
   input  logic [P2C_WORD_W-1:0]    req_plane_word_7,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [P2C_ENTRY_W-1:0]   rsp_pixel_value,
   output logic                     rsp_last_pixel,
   input  logic                     csr_write,
   input  logic [P2C_CSR_IDX_W-1:0] csr_index,
   input  logic [P2C_CSR_W-1:0]     csr_data
);

   logic [P2C_PLANES_W-1:0] source_planes_ff;
   logic [P2C_BYTES_W-1:0]  pixel_bytes_ff;
   logic [P2C_WORD_W-1:0]   all_words [P2C_MAX_PLANES];
   logic [P2C_WORD_W-1:0]   plane_words [MAX_PLANES];
   logic                    accept, start, ready, room;
   p2c_wr_type              wr;
   p2c_rd_type              rd;
   logic                    pal_valid, pal_last;
   logic [P2C_ENTRY_W-1:0]  pal_value;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         source_planes_ff <= P2C_PLANES_RESET;
         pixel_bytes_ff   <= P2C_BYTES_RESET;
      end else if (csr_write) begin
         case (csr_index)
            P2C_REG_SOURCE_PLANES: source_planes_ff <= csr_data[P2C_PLANES_W-1:0];
            P2C_REG_PIXEL_BYTES:   pixel_bytes_ff   <= csr_data[P2C_BYTES_W-1:0];
            default: ;
         endcase
      end
   end

   // Input beat: a load writes the palette, a convert starts a group.
   assign req_stall = !ready;
   assign accept    = req_valid && ready;
   assign start     = accept && (req_mode == P2C_MODE_CONVERT);

   assign wr.en   = accept && (req_mode == P2C_MODE_LOAD);
   assign wr.addr = req_palette_index;
   assign wr.data = req_palette_value;

   assign all_words[0] = req_plane_word_0;
   assign all_words[1] = req_plane_word_1;
   assign all_words[2] = req_plane_word_2;
   assign all_words[3] = req_plane_word_3;
   assign all_words[4] = req_plane_word_4;
   assign all_words[5] = req_plane_word_5;
   assign all_words[6] = req_plane_word_6;
   assign all_words[7] = req_plane_word_7;

   for (genvar k = 0; k < MAX_PLANES; k++) begin : g_planes
      assign plane_words[k] = all_words[k];
   end

   p2c_sequencer #(
      .MAX_PLANES (MAX_PLANES)
   ) u_sequencer (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .plane_words   (plane_words),
      .source_planes (source_planes_ff),
      .room          (room),
      .rd            (rd),
      .ready         (ready)
   );

   p2c_palette u_palette (
      .clock       (clock),
      .reset       (reset),
      .wr          (wr),
      .rd          (rd),
      .pixel_bytes (pixel_bytes_ff),
      .out_valid   (pal_valid),
      .out_value   (pal_value),
      .out_last    (pal_last)
   );

   p2c_out_queue u_out_queue (
      .clock           (clock),
      .reset           (reset),
      .push            (pal_valid),
      .push_value      (pal_value),
      .push_last       (pal_last),
      .in_flight       (pal_valid),
      .room            (room),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_last_pixel  (rsp_last_pixel)
   );

endmodule
